// File: src/vqdm_pkg.sv
// ----------------------------------------------------------------------------
// vqdm_pkg
// Shared types, codes and defaults for the virtqueue descriptor manager.
// ----------------------------------------------------------------------------
package vqdm_pkg;

  localparam int MAX_QUEUE_DEF    = 256;
  localparam int HEADER_BYTES_DEF = 10;
  localparam int QSIZE_W          = 9;
  localparam int RING_CNT_W       = 16;
  localparam logic [QSIZE_W-1:0] QSIZE_RESET = 9'd256;

  typedef enum logic [1:0] {
    OP_INIT     = 2'd0,
    OP_POST     = 2'd1,
    OP_COMPLETE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_NO_FREE = 2'd1,
    STATUS_BAD_ID  = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [63:0] buf_addr;
    logic [15:0] length;
    logic        device_writable;
    logic [7:0]  used_id;
  } in_item_t;

  typedef struct packed {
    status_t      status;
    logic [7:0]   slot_desc;
    logic [7:0]   ring_slot;
    logic [15:0]  ring_count;
    logic [63:0]  found_addr;
    logic [15:0]  payload_len;
    logic         frame_valid;
    logic [8:0]   free_left;
  } out_item_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_INIT,
    S_INIT_FIN,
    S_MOD_AVAIL,
    S_MOD_USED
  } state_t;

  typedef struct packed {
    logic capture;      // latch item, issue descriptor memory reads
    logic exec;         // commit post/complete, load result
    logic sweep;        // write one free-list entry of the sweep
    logic sweep_full;   // sweep covers the whole memory (after reset)
    logic init_fin;     // reset counters, load init result
    logic mod_start;    // start a ring slot remainder pass
    logic mod_sel_used; // remainder pass on used index, else avail index
    logic load_avail;   // take remainder as avail slot
    logic load_used;    // take remainder as used slot
  } ctrl_cmd_t;

  typedef struct packed {
    logic item_is_init;
    logic sweep_last;
    logic mod_done;
  } dp_status_t;

endpackage

// File: src/vqdm_ram.sv
// ----------------------------------------------------------------------------
// vqdm_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module vqdm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: src/vqdm_mod.sv
// ----------------------------------------------------------------------------
// vqdm_mod
// Bit-serial restoring remainder: dividend modulo divisor, one bit a cycle.
// ----------------------------------------------------------------------------
module vqdm_mod #(
  parameter int DVD_W = 16,
  parameter int DIV_W = 9
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DIV_W-1:0] divisor,
  output logic             done,
  output logic [DIV_W-1:0] remainder
);

  localparam int STEP_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

  logic              busy;
  logic [STEP_W-1:0] step_cnt;
  logic [DVD_W-1:0]  dvd;
  logic [DIV_W:0]    trial;
  logic [DIV_W-1:0]  rem_step;

  always_comb begin
    trial = {remainder, dvd[DVD_W-1]};
    if (trial >= {1'b0, divisor}) begin
      rem_step = DIV_W'(trial - {1'b0, divisor});
    end else begin
      rem_step = DIV_W'(trial);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      done     <= 1'b0;
      step_cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        step_cnt <= '0;
      end else if (busy) begin
        step_cnt <= step_cnt + STEP_W'(1);
        if (step_cnt == STEP_W'(DVD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd       <= dividend;
      remainder <= '0;
    end else if (busy) begin
      remainder <= rem_step;
      dvd       <= dvd << 1;
    end
  end

  a_rem_below_divisor: assert property (@(posedge clk) disable iff (rst)
    done && (divisor != '0) |-> remainder < divisor)
    else $error("remainder not below divisor");

endmodule

// File: src/vqdm_ctrl.sv
// ----------------------------------------------------------------------------
// vqdm_ctrl
// Sequencer: clearing pass, item execution, init sweep, slot recompute.
// ----------------------------------------------------------------------------
module vqdm_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_ready,
  output logic                  result_valid,
  input  logic                  result_ready,
  input  logic                  cfg_we,
  input  vqdm_pkg::dp_status_t  sts,
  output vqdm_pkg::ctrl_cmd_t   cmd
);

  vqdm_pkg::state_t state;
  vqdm_pkg::state_t state_next;
  logic             out_free;

  assign out_free = !result_valid || result_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= vqdm_pkg::S_CLEAR;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.exec || cmd.init_fin) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    item_ready = 1'b0;
    unique case (state)
      vqdm_pkg::S_CLEAR: begin
        cmd.sweep      = 1'b1;
        cmd.sweep_full = 1'b1;
        if (sts.sweep_last) begin
          state_next = vqdm_pkg::S_IDLE;
        end
      end
      vqdm_pkg::S_IDLE: begin
        if (cfg_we) begin
          // queue size changed: rebuild both ring slots
          cmd.mod_start = 1'b1;
          state_next    = vqdm_pkg::S_MOD_AVAIL;
        end else begin
          item_ready = 1'b1;
          if (item_valid) begin
            cmd.capture = 1'b1;
            state_next  = sts.item_is_init ? vqdm_pkg::S_INIT : vqdm_pkg::S_EXEC;
          end
        end
      end
      vqdm_pkg::S_EXEC: begin
        if (out_free) begin
          cmd.exec   = 1'b1;
          state_next = vqdm_pkg::S_IDLE;
        end
      end
      vqdm_pkg::S_INIT: begin
        cmd.sweep = 1'b1;
        if (sts.sweep_last) begin
          state_next = vqdm_pkg::S_INIT_FIN;
        end
      end
      vqdm_pkg::S_INIT_FIN: begin
        if (out_free) begin
          cmd.init_fin = 1'b1;
          state_next   = vqdm_pkg::S_IDLE;
        end
      end
      vqdm_pkg::S_MOD_AVAIL: begin
        if (cfg_we) begin
          cmd.mod_start = 1'b1;
        end else if (sts.mod_done) begin
          cmd.load_avail   = 1'b1;
          cmd.mod_start    = 1'b1;
          cmd.mod_sel_used = 1'b1;
          state_next       = vqdm_pkg::S_MOD_USED;
        end
      end
      vqdm_pkg::S_MOD_USED: begin
        if (cfg_we) begin
          cmd.mod_start = 1'b1;
          state_next    = vqdm_pkg::S_MOD_AVAIL;
        end else if (sts.mod_done) begin
          cmd.load_used = 1'b1;
          state_next    = vqdm_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = vqdm_pkg::S_CLEAR;
      end
    endcase
  end

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    item_valid && item_ready |=> state == vqdm_pkg::S_EXEC || state == vqdm_pkg::S_INIT)
    else $error("accepted item did not start execution");

endmodule

// File: src/vqdm_dpath.sv
// ----------------------------------------------------------------------------
// vqdm_dpath
// Descriptor memories, free list, ring counters and result register.
// ----------------------------------------------------------------------------
module vqdm_dpath #(
  parameter int MAX_QUEUE    = vqdm_pkg::MAX_QUEUE_DEF,
  parameter int HEADER_BYTES = vqdm_pkg::HEADER_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  vqdm_pkg::ctrl_cmd_t           cmd,
  output vqdm_pkg::dp_status_t          sts,
  input  vqdm_pkg::in_item_t            item,
  input  logic                          cfg_we,
  input  logic [vqdm_pkg::QSIZE_W-1:0]  cfg_data,
  output vqdm_pkg::out_item_t           result
);

  localparam int CNT_W   = $clog2(MAX_QUEUE + 1);
  localparam int IDX_W   = $clog2(MAX_QUEUE);
  localparam int CMP_W   = (vqdm_pkg::QSIZE_W > CNT_W) ? vqdm_pkg::QSIZE_W : CNT_W;
  localparam int RC_W    = vqdm_pkg::RING_CNT_W;
  localparam int RESET_Q = (MAX_QUEUE < 256) ? MAX_QUEUE : 256;

  logic [vqdm_pkg::QSIZE_W-1:0] qsize;
  vqdm_pkg::in_item_t           item_q;
  logic [CNT_W-1:0]             list_head, list_head_next;
  logic [CNT_W-1:0]             free_total, free_total_next;
  logic [RC_W-1:0]              avail_index, avail_index_next;
  logic [RC_W-1:0]              used_index, used_index_next;
  logic [IDX_W-1:0]             avail_pos, avail_pos_next;
  logic [IDX_W-1:0]             used_slot, used_slot_next;
  logic [CNT_W-1:0]             sweep_cnt;
  logic [CNT_W-1:0]             sweep_limit;
  logic [CNT_W-1:0]             eff_q;
  logic [CMP_W-1:0]             qs_ext;
  logic                         post_ok;
  logic                         id_bad;
  logic [IDX_W-1:0]             di;
  logic [IDX_W-1:0]             id_idx;
  logic [IDX_W-1:0]             avail_pos_inc, used_slot_inc;
  vqdm_pkg::out_item_t          res;

  logic [IDX_W-1:0] rd_addr;
  logic [CNT_W-1:0] link_rdata;
  logic [63:0]      addr_rdata;
  logic             link_we, desc_we, flag_we, ring_we;
  logic [IDX_W-1:0] wr_addr;
  logic [CNT_W-1:0] link_wdata;
  logic             flag_wdata;

  logic             mod_done;
  logic [CNT_W-1:0] mod_rem;

  // effective queue size, saturated to 1..MAX_QUEUE
  always_comb begin
    qs_ext = CMP_W'(qsize);
    if (qsize == '0) begin
      eff_q = CNT_W'(1);
    end else if (qs_ext > CMP_W'(MAX_QUEUE)) begin
      eff_q = CNT_W'(MAX_QUEUE);
    end else begin
      eff_q = CNT_W'(qs_ext);
    end
  end

  assign sweep_limit      = cmd.sweep_full ? CNT_W'(MAX_QUEUE) : eff_q;
  assign sts.sweep_last   = (sweep_cnt == sweep_limit - CNT_W'(1));
  assign sts.item_is_init = (item.op == vqdm_pkg::OP_INIT);
  assign sts.mod_done     = mod_done;

  assign rd_addr = (item.op == vqdm_pkg::OP_COMPLETE) ? IDX_W'(item.used_id)
                                                     : list_head[IDX_W-1:0];

  assign post_ok = (free_total != '0) && (list_head < eff_q);
  assign id_bad  = CMP_W'(item_q.used_id) >= CMP_W'(eff_q);
  assign di      = list_head[IDX_W-1:0];
  assign id_idx  = IDX_W'(item_q.used_id);

  // restart the slot at zero when it reaches the queue size or the 16-bit index wraps
  assign avail_pos_inc = ((avail_index == '1) ||
                          (CNT_W'(avail_pos) + CNT_W'(1) == eff_q)) ? '0
                                                                    : avail_pos + IDX_W'(1);
  assign used_slot_inc = ((used_index == '1) ||
                          (CNT_W'(used_slot) + CNT_W'(1) == eff_q)) ? '0
                                                                    : used_slot + IDX_W'(1);

  always_comb begin
    res              = '0;
    res.status       = vqdm_pkg::STATUS_OK;
    list_head_next   = list_head;
    free_total_next  = free_total;
    avail_index_next = avail_index;
    used_index_next  = used_index;
    avail_pos_next   = avail_pos;
    used_slot_next   = used_slot;
    link_we          = 1'b0;
    desc_we          = 1'b0;
    flag_we          = 1'b0;
    ring_we          = 1'b0;
    wr_addr          = sweep_cnt[IDX_W-1:0];
    link_wdata       = sweep_cnt + CNT_W'(1);
    flag_wdata       = 1'b0;

    if (cmd.sweep) begin
      link_we = 1'b1;
      flag_we = 1'b1;
    end

    if (cmd.init_fin) begin
      list_head_next   = '0;
      free_total_next  = eff_q;
      avail_index_next = '0;
      used_index_next  = '0;
      avail_pos_next   = '0;
      used_slot_next   = '0;
    end

    if (cmd.exec) begin
      unique case (item_q.op)
        vqdm_pkg::OP_POST: begin
          if (post_ok) begin
            list_head_next   = link_rdata;
            free_total_next  = free_total - CNT_W'(1);
            link_we          = 1'b1;
            wr_addr          = di;
            link_wdata       = '0;
            desc_we          = 1'b1;
            flag_we          = 1'b1;
            flag_wdata       = item_q.device_writable;
            ring_we          = 1'b1;
            avail_index_next = avail_index + RC_W'(1);
            avail_pos_next   = avail_pos_inc;
            res.slot_desc    = 8'(di);
            res.ring_slot    = 8'(avail_pos);
            res.ring_count   = avail_index_next;
          end else begin
            res.status = vqdm_pkg::STATUS_NO_FREE;
          end
        end
        vqdm_pkg::OP_COMPLETE: begin
          used_index_next = used_index + RC_W'(1);
          used_slot_next  = used_slot_inc;
          res.slot_desc   = item_q.used_id;
          res.ring_slot   = 8'(used_slot);
          res.ring_count  = used_index_next;
          if (id_bad) begin
            res.status = vqdm_pkg::STATUS_BAD_ID;
          end else begin
            res.found_addr = addr_rdata;
            if (item_q.length > 16'(HEADER_BYTES)) begin
              res.frame_valid = 1'b1;
              res.payload_len = item_q.length - 16'(HEADER_BYTES);
            end
            // push the descriptor back onto the free list
            link_we        = 1'b1;
            wr_addr        = id_idx;
            link_wdata     = list_head;
            flag_we        = 1'b1;
            flag_wdata     = 1'b0;
            list_head_next = CNT_W'(item_q.used_id);
            if (free_total < eff_q) begin
              free_total_next = free_total + CNT_W'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end

    if (cmd.load_avail) begin
      avail_pos_next = IDX_W'(mod_rem);
    end
    if (cmd.load_used) begin
      used_slot_next = IDX_W'(mod_rem);
    end

    res.free_left = 9'(free_total_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      qsize       <= vqdm_pkg::QSIZE_RESET;
      list_head   <= '0;
      free_total  <= CNT_W'(RESET_Q);
      avail_index <= '0;
      used_index  <= '0;
      avail_pos   <= '0;
      used_slot   <= '0;
      sweep_cnt   <= '0;
    end else begin
      if (cfg_we) begin
        qsize <= cfg_data;
      end
      list_head   <= list_head_next;
      free_total  <= free_total_next;
      avail_index <= avail_index_next;
      used_index  <= used_index_next;
      avail_pos   <= avail_pos_next;
      used_slot   <= used_slot_next;
      if (cmd.capture) begin
        sweep_cnt <= '0;
      end else if (cmd.sweep) begin
        sweep_cnt <= sweep_cnt + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_q <= item;
    end
    if (cmd.exec || cmd.init_fin) begin
      result <= res;
    end
  end

  vqdm_ram #(.WIDTH(CNT_W), .DEPTH(MAX_QUEUE)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (wr_addr),
    .wdata (link_wdata),
    .re    (cmd.capture),
    .raddr (rd_addr),
    .rdata (link_rdata)
  );

  vqdm_ram #(.WIDTH(64), .DEPTH(MAX_QUEUE)) u_addr_ram (
    .clk   (clk),
    .we    (desc_we),
    .waddr (di),
    .wdata (item_q.buf_addr),
    .re    (cmd.capture),
    .raddr (rd_addr),
    .rdata (addr_rdata)
  );

  vqdm_ram #(.WIDTH(16), .DEPTH(MAX_QUEUE)) u_len_ram (
    .clk   (clk),
    .we    (desc_we),
    .waddr (di),
    .wdata (item_q.length),
    .re    (1'b0),
    .raddr (rd_addr),
    .rdata ()
  );

  vqdm_ram #(.WIDTH(1), .DEPTH(MAX_QUEUE)) u_flag_ram (
    .clk   (clk),
    .we    (flag_we),
    .waddr (wr_addr),
    .wdata (flag_wdata),
    .re    (1'b0),
    .raddr (rd_addr),
    .rdata ()
  );

  vqdm_ram #(.WIDTH(IDX_W), .DEPTH(MAX_QUEUE)) u_ring_ram (
    .clk   (clk),
    .we    (ring_we),
    .waddr (avail_pos),
    .wdata (di),
    .re    (1'b0),
    .raddr (rd_addr),
    .rdata ()
  );

  vqdm_mod #(.DVD_W(RC_W), .DIV_W(CNT_W)) u_mod (
    .clk       (clk),
    .rst       (rst),
    .start     (cmd.mod_start),
    .dividend  (cmd.mod_sel_used ? used_index : avail_index),
    .divisor   (eff_q),
    .done      (mod_done),
    .remainder (mod_rem)
  );

  a_post_takes_one: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && (item_q.op == vqdm_pkg::OP_POST) && post_ok
      |=> free_total == $past(free_total) - CNT_W'(1))
    else $error("successful post did not take one free descriptor");

  a_complete_advances_used: assert property (@(posedge clk) disable iff (rst)
    cmd.exec && (item_q.op == vqdm_pkg::OP_COMPLETE)
      |=> used_index == $past(used_index) + RC_W'(1))
    else $error("complete did not advance used index");

endmodule

// File: src/virtqueue_descriptor_manager.sv
// ----------------------------------------------------------------------------
// virtqueue_descriptor_manager
// Split virtqueue descriptor manager: free list, post and complete.
//
// Post and complete each accept the item and read the descriptor memories at
// the free-list head or the used id, then, once the output register is free,
// update the free list and counters and load the result register. Init
// accepts the item, rewrites one free-list entry per cycle over the queue
// size, then resets the counters and loads the result. After reset a clearing
// pass over all MAX_QUEUE entries rebuilds the free list before the first item
// is taken. A queue size write starts two bit-serial remainder passes, on the
// avail and then the used index, that re-derive the ring slots; no item is
// taken until they finish. A finished result waits in the output register
// while the next item is accepted.
// ----------------------------------------------------------------------------
module virtqueue_descriptor_manager #(
  parameter int MAX_QUEUE    = vqdm_pkg::MAX_QUEUE_DEF,
  parameter int HEADER_BYTES = vqdm_pkg::HEADER_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          item_valid,
  output logic                          item_ready,
  input  vqdm_pkg::in_item_t            item,
  output logic                          result_valid,
  input  logic                          result_ready,
  output vqdm_pkg::out_item_t           result,
  input  logic                          cfg_we,
  input  logic [vqdm_pkg::QSIZE_W-1:0]  cfg_data
);

  vqdm_pkg::ctrl_cmd_t  cmd;
  vqdm_pkg::dp_status_t sts;

  vqdm_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .cfg_we       (cfg_we),
    .sts          (sts),
    .cmd          (cmd)
  );

  vqdm_dpath #(
    .MAX_QUEUE    (MAX_QUEUE),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dpath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .item     (item),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .result   (result)
  );

endmodule

// File: tb/virtqueue_descriptor_manager_tb.sv
// ----------------------------------------------------------------------------
// virtqueue_descriptor_manager_tb
// Self-checking regression for the split virtqueue descriptor manager. A
// behavioural copy of the free list and ring counters predicts every result
// at item acceptance. Directed items cover field extremes, every op and the
// corner cases. Random post/complete traffic then runs over several queue
// sizes, with bursty input, receiver stalls and one long hold-off.
// ----------------------------------------------------------------------------
module virtqueue_descriptor_manager_tb;

  localparam int QMAX          = vqdm_pkg::MAX_QUEUE_DEF;
  localparam int HDR           = vqdm_pkg::HEADER_BYTES_DEF;
  localparam int QW            = vqdm_pkg::QSIZE_W;
  localparam logic [1:0] OP_RESERVED = 2'd3;
  localparam int RANDOM_ITEMS  = 1700;
  localparam int PHASE_ITEMS   = 140;
  localparam int LONG_HOLD     = 200;
  localparam int SETTLE_CYCLES = 40;
  localparam int LIMIT_CYCLES  = 2000000;

  typedef enum int {READY_FULL, READY_COIN, READY_MOSTLY, READY_STALL} ready_mode_t;

  logic                 clk          = 1'b0;
  logic                 rst          = 1'b1;
  logic                 item_valid   = 1'b0;
  logic                 item_ready;
  vqdm_pkg::in_item_t   item         = '0;
  logic                 result_valid;
  logic                 result_ready = 1'b0;
  vqdm_pkg::out_item_t  result;
  logic                 cfg_we       = 1'b0;
  logic [QW-1:0]        cfg_data     = vqdm_pkg::QSIZE_RESET;

  // behavioural copy of the queue
  logic [8:0]           link_mem [QMAX];
  logic [63:0]          addr_mem [QMAX];
  bit                   written  [QMAX];
  logic [8:0]           head;
  logic [8:0]           n_free;
  logic [15:0]          avail_idx;
  logic [15:0]          used_idx;
  logic [8:0]           qsize_reg;
  logic [7:0]           on_loan [$];
  vqdm_pkg::out_item_t  outcomes_due [$];

  int                   mismatches = 0;
  int                   items_sent = 0;
  int unsigned          burst_left = 0;
  bit                   hold_req   = 1'b0;
  int unsigned          hold_left  = 0;
  int unsigned          run_left   = 0;
  ready_mode_t          ready_mode = READY_FULL;

  virtqueue_descriptor_manager u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int unsigned eff_queue();
    if (qsize_reg == 0) return 1;
    if (qsize_reg > QMAX) return QMAX;
    return 32'(qsize_reg);
  endfunction

  function automatic void reset_queue_copy();
    qsize_reg = vqdm_pkg::QSIZE_RESET;
    for (int i = 0; i < QMAX; i++) begin
      link_mem[i] = 9'(i + 1);
      addr_mem[i] = '0;
      written[i]  = 1'b0;
    end
    head      = '0;
    n_free    = 9'(eff_queue());
    avail_idx = '0;
    used_idx  = '0;
    on_loan.delete();
  endfunction

  // Advance the queue copy by one item and return the result it must give.
  function automatic vqdm_pkg::out_item_t virtqueue_outcome(vqdm_pkg::in_item_t it);
    vqdm_pkg::out_item_t r;
    int unsigned         q;
    int unsigned         d;
    int unsigned         slot;
    r = '0;
    q = eff_queue();
    case (it.op)
      vqdm_pkg::OP_INIT: begin
        for (int i = 0; i < q; i++) link_mem[i] = 9'(i + 1);
        head      = '0;
        n_free    = 9'(q);
        avail_idx = '0;
        used_idx  = '0;
        on_loan.delete();
      end
      vqdm_pkg::OP_POST: begin
        if (n_free == 0 || head >= q) begin
          r.status = vqdm_pkg::STATUS_NO_FREE;
        end else begin
          d           = 32'(head);
          slot        = avail_idx % q;
          head        = link_mem[d];
          n_free      = n_free - 1'b1;
          addr_mem[d] = it.buf_addr;
          link_mem[d] = '0;
          written[d]  = 1'b1;
          avail_idx   = avail_idx + 1'b1;
          on_loan.push_back(8'(d));
          r.slot_desc  = 8'(d);
          r.ring_slot  = 8'(slot);
          r.ring_count = avail_idx;
        end
      end
      vqdm_pkg::OP_COMPLETE: begin
        slot        = used_idx % q;
        d           = 32'(it.used_id);
        r.slot_desc = it.used_id;
        if (d >= q) begin
          r.status = vqdm_pkg::STATUS_BAD_ID;
        end else begin
          r.found_addr = addr_mem[d];
          if (it.length > HDR) begin
            r.frame_valid = 1'b1;
            r.payload_len = it.length - 16'(HDR);
          end
          link_mem[d] = head;
          head        = 9'(d);
          if (n_free < q) n_free = n_free + 1'b1;
          for (int k = 0; k < on_loan.size(); k++) begin
            if (on_loan[k] == 8'(d)) begin
              on_loan.delete(k);
              break;
            end
          end
        end
        used_idx     = used_idx + 1'b1;
        r.ring_slot  = 8'(slot);
        r.ring_count = used_idx;
      end
      default: ;
    endcase
    r.free_left = n_free;
    return r;
  endfunction

  function automatic vqdm_pkg::in_item_t make_item(logic [1:0] op, logic [63:0] addr,
                                                   logic [15:0] len, logic wr,
                                                   logic [7:0] id);
    vqdm_pkg::in_item_t it;
    it.op              = op;
    it.buf_addr        = addr;
    it.length          = len;
    it.device_writable = wr;
    it.used_id         = id;
    return it;
  endfunction

  // Mostly well-formed post/complete traffic over descriptors on loan, with
  // bad ids, repeated returns, reserved ops and the odd re-init mixed in.
  function automatic vqdm_pkg::in_item_t make_traffic_item();
    vqdm_pkg::in_item_t it;
    int unsigned        q;
    int unsigned        pick;
    int unsigned        cand [$];
    it.op              = vqdm_pkg::OP_POST;
    it.buf_addr        = {$urandom, $urandom};
    it.device_writable = 1'($urandom_range(0, 1));
    it.used_id         = 8'($urandom_range(0, 255));
    case ($urandom_range(0, 11))
      0:       it.length = 16'd0;
      1:       it.length = 16'(HDR);
      2:       it.length = 16'(HDR + 1);
      3:       it.length = 16'd1500;
      4:       it.length = 16'hffff;
      default: it.length = 16'($urandom_range(0, 65535));
    endcase
    q    = eff_queue();
    pick = $urandom_range(0, 99);
    if (pick < 2) begin
      it.op = vqdm_pkg::OP_INIT;
    end else if (pick < 4) begin
      it.op = OP_RESERVED;
    end else if (pick < 7 && q < 256) begin
      it.op      = vqdm_pkg::OP_COMPLETE;
      it.used_id = 8'($urandom_range(q, 255));
    end else if (pick < 10) begin
      // return any written descriptor, free or not
      for (int i = 0; i < q; i++) if (written[i]) cand.push_back(i);
      if (cand.size() != 0) begin
        it.op      = vqdm_pkg::OP_COMPLETE;
        it.used_id = 8'(cand[$urandom_range(0, cand.size() - 1)]);
      end
    end else if (pick < 13) begin
      // post whatever the free list holds, empty or not
    end else if (on_loan.size() != 0 &&
                 (n_free == 0 || head >= q || $urandom_range(0, 99) < 45)) begin
      it.op      = vqdm_pkg::OP_COMPLETE;
      it.used_id = on_loan[$urandom_range(0, on_loan.size() - 1)];
    end
    return it;
  endfunction

  task automatic note_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch on %s: got %0h, want %0h", what, got, want);
    mismatches++;
  endtask

  // Hold the item until taken; gaps fall only between bursts.
  task automatic send_item(vqdm_pkg::in_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        item_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    item       = it;
    item_valid = 1'b1;
    do @(posedge clk); while (!item_ready);
    outcomes_due.push_back(virtqueue_outcome(it));
    if (it.op != OP_RESERVED) items_sent++;
    @(negedge clk);
  endtask

  task automatic drain();
    item_valid = 1'b0;
    while (outcomes_due.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_queue_size(logic [QW-1:0] v);
    cfg_data = v;
    cfg_we   = 1'b1;
    @(negedge clk);
    cfg_we    = 1'b0;
    qsize_reg = v;
  endtask

  task automatic test_directed_ops();
    send_item(make_item(vqdm_pkg::OP_POST, '1, 16'hffff, 1'b1, 8'hff));
    send_item(make_item(vqdm_pkg::OP_POST, '0, 16'd0, 1'b0, 8'h00));
    send_item(make_item(vqdm_pkg::OP_POST, 64'h0123_4567_89ab_cdef, 16'd14, 1'b1, 8'h5a));
    send_item(make_item(vqdm_pkg::OP_COMPLETE, '0, 16'd0, 1'b0, 8'd1));
    send_item(make_item(vqdm_pkg::OP_COMPLETE, '1, 16'(HDR), 1'b1, 8'd0));
    send_item(make_item(vqdm_pkg::OP_COMPLETE, '0, 16'(HDR + 1), 1'b0, 8'd2));
    send_item(make_item(vqdm_pkg::OP_POST, 64'hfedc_ba98_7654_3210, 16'd1500, 1'b0, 8'ha5));
    send_item(make_item(vqdm_pkg::OP_COMPLETE, '0, 16'hffff, 1'b0, 8'd2));
    // returned twice: free count must stay at the queue size
    send_item(make_item(vqdm_pkg::OP_COMPLETE, '0, 16'd1500, 1'b0, 8'd2));
    send_item(make_item(OP_RESERVED, '1, 16'hffff, 1'b1, 8'hff));
    send_item(make_item(vqdm_pkg::OP_INIT, '1, 16'hffff, 1'b1, 8'hff));
    send_item(make_item(vqdm_pkg::OP_POST, 64'h8000_0000_0000_0001, 16'h8000, 1'b1, 8'h80));
    send_item(make_item(vqdm_pkg::OP_COMPLETE, '0, 16'h7fff, 1'b0, 8'd0));
    drain();
  endtask

  task automatic test_queue_extremes();
    set_queue_size(9'd1);
    send_item(make_item(vqdm_pkg::OP_INIT, '0, '0, 1'b0, '0));
    send_item(make_item(vqdm_pkg::OP_POST, 64'h1111_2222_3333_4444, 16'd64, 1'b1, '0));
    send_item(make_item(vqdm_pkg::OP_POST, 64'h5555_6666_7777_8888, 16'd64, 1'b0, '0));
    send_item(make_item(vqdm_pkg::OP_COMPLETE, '0, 16'd1500, 1'b0, 8'd0));
    send_item(make_item(vqdm_pkg::OP_COMPLETE, '0, 16'd1500, 1'b0, 8'd200));
    send_item(make_item(vqdm_pkg::OP_COMPLETE, '0, 16'd0, 1'b0, 8'd255));
    send_item(make_item(vqdm_pkg::OP_POST, 64'h0000_0000_ffff_ffff, 16'd1, 1'b1, '0));
    drain();
    set_queue_size(9'd0);
    send_item(make_item(vqdm_pkg::OP_INIT, '0, '0, 1'b0, '0));
    send_item(make_item(vqdm_pkg::OP_POST, 64'hffff_ffff_0000_0000, 16'd100, 1'b0, '0));
    send_item(make_item(vqdm_pkg::OP_COMPLETE, '0, 16'(HDR + 1), 1'b0, 8'd0));
    drain();
    set_queue_size(9'd511);
    send_item(make_item(vqdm_pkg::OP_INIT, '0, '0, 1'b0, '0));
    send_item(make_item(vqdm_pkg::OP_COMPLETE, '0, 16'd2000, 1'b0, 8'd0));
    drain();
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    repeat (16) send_item(make_traffic_item());
    drain();
  endtask

  task automatic test_random_traffic();
    logic [QW-1:0] plan [12];
    logic [QW-1:0] qs;
    int            phase;
    int            stop_at;
    int            phase_end;
    plan    = '{9'd256, 9'd4, 9'd0, 9'd1, 9'd2, 9'd511, 9'd255, 9'd257, 9'd16, 9'd3,
                9'd64, 9'd7};
    phase   = 0;
    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      if (phase < 12) qs = plan[phase];
      else qs = $urandom_range(0, 1) ? QW'($urandom_range(1, 24))
                                     : QW'($urandom_range(0, 511));
      set_queue_size(qs);
      // now and then keep the old free list across a size change
      if (phase % 4 != 3)
        send_item(make_item(vqdm_pkg::OP_INIT, {$urandom, $urandom},
                            16'($urandom_range(0, 65535)),
                            1'($urandom_range(0, 1)), 8'($urandom_range(0, 255))));
      phase_end = items_sent + PHASE_ITEMS;
      while (items_sent < phase_end && items_sent < stop_at)
        send_item(make_traffic_item());
      drain();
      phase++;
    end
  endtask

  always @(negedge clk) begin
    if (hold_req) begin
      hold_left = LONG_HOLD;
      hold_req  = 1'b0;
    end
    if (hold_left != 0) begin
      result_ready = 1'b0;
      hold_left--;
    end else begin
      if (run_left == 0) begin
        ready_mode = ready_mode_t'($urandom_range(0, 3));
        run_left = (ready_mode == READY_STALL) ? $urandom_range(1, 8) : $urandom_range(4, 40);
      end
      run_left--;
      case (ready_mode)
        READY_FULL:   result_ready = 1'b1;
        READY_COIN:   result_ready = 1'($urandom_range(0, 1));
        READY_MOSTLY: result_ready = ($urandom_range(0, 3) != 0);
        default:      result_ready = 1'b0;
      endcase
    end
  end

  always @(posedge clk) begin
    vqdm_pkg::out_item_t want;
    if (!rst && result_valid && result_ready) begin
      if (outcomes_due.size() == 0) begin
        note_mismatch("unexpected result", 64'(result.slot_desc), '0);
      end else begin
        want = outcomes_due.pop_front();
        if (result.status !== want.status)
          note_mismatch("status", 64'(result.status), 64'(want.status));
        if (result.slot_desc !== want.slot_desc)
          note_mismatch("slot_desc", 64'(result.slot_desc), 64'(want.slot_desc));
        if (result.ring_slot !== want.ring_slot)
          note_mismatch("ring_slot", 64'(result.ring_slot), 64'(want.ring_slot));
        if (result.ring_count !== want.ring_count)
          note_mismatch("ring_count", 64'(result.ring_count), 64'(want.ring_count));
        if (result.found_addr !== want.found_addr)
          note_mismatch("found_addr", result.found_addr, want.found_addr);
        if (result.payload_len !== want.payload_len)
          note_mismatch("payload_len", 64'(result.payload_len), 64'(want.payload_len));
        if (result.frame_valid !== want.frame_valid)
          note_mismatch("frame_valid", 64'(result.frame_valid), 64'(want.frame_valid));
        if (result.free_left !== want.free_left)
          note_mismatch("free_left", 64'(result.free_left), 64'(want.free_left));
      end
    end
  end

  initial begin
    reset_queue_copy();
    repeat (4) @(negedge clk);
    rst = 1'b0;
    test_directed_ops();
    test_queue_extremes();
    test_backpressure();
    test_random_traffic();
    drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (outcomes_due.size() != 0)
      note_mismatch("results outstanding", 64'(outcomes_due.size()), '0);
    if (mismatches == 0) begin
      $display("virtqueue_descriptor_manager regression: pass");
    end else begin
      $display("virtqueue_descriptor_manager regression: fail");
    end
    $finish;
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("virtqueue_descriptor_manager regression: fail");
    $finish;
  end

endmodule

// File: sim.f
src/vqdm_pkg.sv
src/vqdm_ram.sv
src/vqdm_mod.sv
src/vqdm_ctrl.sv
src/vqdm_dpath.sv
src/virtqueue_descriptor_manager.sv
tb/virtqueue_descriptor_manager_tb.sv
